// File: src/artu_pkg.sv
// Shared types, command codes and GF(2^8) helpers for the AES round transform unit.
package artu_pkg;

	localparam int NumLanes = 4;

	typedef enum logic [2:0] {
		CMD_SUB       = 3'd0,
		CMD_SHIFT     = 3'd1,
		CMD_MIX       = 3'd2,
		CMD_ADDKEY    = 3'd3,
		CMD_INV_SUB   = 3'd4,
		CMD_INV_SHIFT = 3'd5,
		CMD_INV_MIX   = 3'd6,
		CMD_PASS      = 3'd7
	} cmd_t;

	typedef logic [7:0] byte_t;
	typedef byte_t [3:0] column_t;

	typedef struct packed {
		logic [63:0] state_hi;
		logic [63:0] state_lo;
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic [2:0]  cmd;
	} item_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} result_t;

	localparam byte_t FWD_SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam byte_t INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	// multiply by x, reduction 0x1b
	function automatic byte_t xtime(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

endpackage

// File: src/artu_stream_if.sv
// Valid/ready stream interface carrying one payload.
interface artu_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: src/aes_round_transform_unit_top.sv
// Result valid the cycle after an input transfer; throughput one item per cycle unless the output stalls.
// Four column lanes and a row-rotation merge feed a single output register.
// The input is held only by a stalled output register; ready = !valid_q || out ready.
// Reset (arst_n, asynchronous) clears the output valid flag; data is not reset.
module aes_round_transform_unit_top import artu_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	artu_stream_if.sink       in_ch,
	artu_stream_if.source     out_ch
);
	item_t            item;
	cmd_t             cmd;
	byte_t            sb [16];
	byte_t            kb [16];
	column_t [3:0]    cols, keys, lane_res;
	result_t          res_d, res_q;
	logic             valid_q;
	logic             take;

	assign item = in_ch.payload;
	assign cmd  = cmd_t'(item.cmd);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sb[i]   = item.state_hi[63-8*i -: 8];
			sb[i+8] = item.state_lo[63-8*i -: 8];
			kb[i]   = item.key_hi[63-8*i -: 8];
			kb[i+8] = item.key_lo[63-8*i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				cols[c][r] = sb[r*4+c];
				keys[c][r] = kb[r*4+c];
			end
		end
	end

	for (genvar g = 0; g < NumLanes; g++) begin : g_lane
		artu_column_lane u_lane (
			.cmd (cmd),
			.col (cols[g]),
			.key (keys[g]),
			.res (lane_res[g])
		);
	end

	artu_merge u_merge (
		.cmd  (cmd),
		.orig (cols),
		.lane (lane_res),
		.res  (res_d)
	);

	assign in_ch.ready = !valid_q || out_ch.ready;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign out_ch.valid   = valid_q;
	assign out_ch.payload = res_q;
endmodule

// File: src/artu_column_lane.sv
// One column lane: sub/inv-sub bytes, add key, mix/inv-mix or pass-through on one four-byte column.
module artu_column_lane import artu_pkg::*; (
	input  cmd_t    cmd,
	input  column_t col,
	input  column_t key,
	output column_t res
);
	column_t x2, x4, x8, mix_f, mix_i;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			x2[r] = xtime(col[r]);
			x4[r] = xtime(x2[r]);
			x8[r] = xtime(x4[r]);
		end
		for (int r = 0; r < 4; r++) begin
			// 2 3 1 1 circulant
			mix_f[r] = x2[r] ^ x2[(r+1)%4] ^ col[(r+1)%4] ^ col[(r+2)%4] ^ col[(r+3)%4];
			// 14 11 13 9 circulant
			mix_i[r] = (x8[r] ^ x4[r] ^ x2[r])
				^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ col[(r+1)%4])
				^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ col[(r+2)%4])
				^ (x8[(r+3)%4] ^ col[(r+3)%4]);
		end
		for (int r = 0; r < 4; r++) begin
			case (cmd)
				CMD_SUB:     res[r] = FWD_SBOX[col[r]];
				CMD_INV_SUB: res[r] = INV_SBOX[col[r]];
				CMD_ADDKEY:  res[r] = col[r] ^ key[r];
				CMD_MIX:     res[r] = mix_f[r];
				CMD_INV_MIX: res[r] = mix_i[r];
				default:     res[r] = col[r];
			endcase
		end
	end
endmodule

// File: src/artu_merge.sv
// Merge stage: applies row rotations and reassembles lane outputs into the result.
module artu_merge import artu_pkg::*; (
	input  cmd_t              cmd,
	input  column_t [3:0]     orig,
	input  column_t [3:0]     lane,
	output result_t           res
);
	byte_t t [16];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				case (cmd)
					CMD_SHIFT:     t[r*4+c] = orig[(c+r)%4][r];
					CMD_INV_SHIFT: t[r*4+c] = orig[(c+4-r)%4][r];
					default:       t[r*4+c] = lane[c][r];
				endcase
			end
		end
		res.result_hi = {t[0], t[1], t[2], t[3], t[4], t[5], t[6], t[7]};
		res.result_lo = {t[8], t[9], t[10], t[11], t[12], t[13], t[14], t[15]};
	end
endmodule

// File: src/artu_checker.sv
// Port-level checker for the AES round transform unit, bound to the top level.
module artu_checker import artu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [63:0] out_hi
);
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("input stalled with empty output");
	a_ready_when_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready) else $error("input stalled while output drains");
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid) else $error("result missing after transfer");
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && in_ready) && !(out_valid && !out_ready)) |=> !out_valid)
		else $error("result without input transfer");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_hi)) else $error("stalled result changed");
endmodule

bind aes_round_transform_unit_top artu_checker u_artu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_hi    (out_ch.payload.result_hi)
);
